// ===== src/subenum_pkg.sv =====
// ----------------------------------------------------------------------------
// subenum_pkg
// Shared constants, types and field layout for the subset enumerator.
// ----------------------------------------------------------------------------
package subenum_pkg;

  localparam int MAX_MEMBERS = 4;
  localparam int ID_WIDTH    = 8;
  localparam int CNT_W       = 3;
  localparam int IDX_W       = (MAX_MEMBERS > 1) ? $clog2(MAX_MEMBERS) : 1;

  localparam int IN_BITS     = CNT_W + MAX_MEMBERS * ID_WIDTH;
  localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
  localparam int IN_ID_LSB   = CNT_W;

  localparam int OUT_BITS    = MAX_MEMBERS + CNT_W + MAX_MEMBERS * ID_WIDTH;
  localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;
  localparam int OUT_SZ_LSB  = MAX_MEMBERS;
  localparam int OUT_ID_LSB  = MAX_MEMBERS + CNT_W;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } dp_cmd_t;

  typedef struct packed {
    logic count_zero;
    logic last;
  } dp_sts_t;

endpackage

// ===== src/subenum_ctrl.sv =====
// ----------------------------------------------------------------------------
// subenum_ctrl
// Controller: loads a request, then steps the mask once per taken output beat before the last.
// ----------------------------------------------------------------------------
module subenum_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  subenum_pkg::dp_sts_t sts,
  output subenum_pkg::dp_cmd_t cmd
);
  import subenum_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt   = state_r;
    in_tready   = 1'b0;
    out_tvalid  = 1'b0;
    cmd.load    = 1'b0;
    cmd.advance = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid && !sts.count_zero) begin
          cmd.load  = 1'b1;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        out_tvalid = 1'b1;
        if (out_tready) begin
          if (sts.last) begin
            state_nxt = ST_IDLE;
          end else begin
            cmd.advance = 1'b1;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input and output active together");

  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && sts.last) |=> in_tready)
    else $error("not idle after last beat");

  a_load_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> out_tvalid)
    else $error("no output after load");

endmodule

// ===== src/subenum_dp.sv =====
// ----------------------------------------------------------------------------
// subenum_dp
// Datapath: holds ids, mask counter and run end; packs the selected ids.
// ----------------------------------------------------------------------------
module subenum_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [subenum_pkg::IN_DATA_W-1:0] in_tdata,
  output logic [subenum_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                              out_tlast,
  input  subenum_pkg::dp_cmd_t              cmd,
  output subenum_pkg::dp_sts_t              sts
);
  import subenum_pkg::*;

  logic [MAX_MEMBERS-1:0] mask_r;
  logic [MAX_MEMBERS-1:0] mask_nxt;
  logic [MAX_MEMBERS-1:0] run_end_r;
  logic [MAX_MEMBERS-1:0] run_end_nxt;
  logic [ID_WIDTH-1:0]    ids_r [MAX_MEMBERS];
  logic [CNT_W-1:0]       cnt_in;
  logic [CNT_W-1:0]       cnt_sat;
  logic [ID_WIDTH-1:0]    packed_ids [MAX_MEMBERS];
  logic [CNT_W-1:0]       size;

  assign cnt_in  = in_tdata[CNT_W-1:0];
  assign cnt_sat = (cnt_in > CNT_W'(MAX_MEMBERS)) ? CNT_W'(MAX_MEMBERS) : cnt_in;
  assign run_end_nxt = {MAX_MEMBERS{1'b1}} >> (CNT_W'(MAX_MEMBERS) - cnt_sat);

  assign sts.count_zero = (cnt_in == '0);
  assign sts.last       = (mask_r == run_end_r);

  always_comb begin
    mask_nxt = mask_r;
    if (cmd.load) begin
      mask_nxt = MAX_MEMBERS'(1);
    end else if (cmd.advance) begin
      mask_nxt = mask_r + MAX_MEMBERS'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_r    <= '0;
      run_end_r <= '0;
    end else begin
      mask_r <= mask_nxt;
      if (cmd.load) begin
        run_end_r <= run_end_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      for (int p = 0; p < MAX_MEMBERS; p++) begin
        ids_r[p] <= in_tdata[IN_ID_LSB + p*ID_WIDTH +: ID_WIDTH];
      end
    end
  end

  // compact selected ids in position order
  always_comb begin
    size = '0;
    for (int k = 0; k < MAX_MEMBERS; k++) begin
      packed_ids[k] = '0;
    end
    for (int p = 0; p < MAX_MEMBERS; p++) begin
      if (mask_r[p]) begin
        packed_ids[size[IDX_W-1:0]] = ids_r[p];
        size = size + CNT_W'(1);
      end
    end
  end

  always_comb begin
    out_tdata = '0;
    out_tdata[MAX_MEMBERS-1:0] = mask_r;
    out_tdata[OUT_SZ_LSB +: CNT_W] = size;
    for (int k = 0; k < MAX_MEMBERS; k++) begin
      out_tdata[OUT_ID_LSB + k*ID_WIDTH +: ID_WIDTH] = packed_ids[k];
    end
  end

  assign out_tlast = sts.last;

  a_load_mask: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (mask_r == MAX_MEMBERS'(1)))
    else $error("mask not one after load");

  a_advance: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |=> (mask_r == $past(mask_r) + MAX_MEMBERS'(1)))
    else $error("mask did not step");

  a_no_step_past_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.advance |-> !sts.last)
    else $error("mask stepped past run end");

endmodule

// ===== src/subset_enumerator_unit.sv =====
// ----------------------------------------------------------------------------
// subset_enumerator_unit
// Emits every nonempty subset of a request's ids, one output beat per cycle while out_tready is high.
// The first beat is valid in the cycle after acceptance. Each request yields
// 2^count - 1 beats (count saturated at four members); the mask counter steps
// once per taken beat before the last. A new request is taken only when idle.
// A zero-count request is taken and produces no beats.
// Reset (rst_n low, synchronous) returns the controller to idle.
// ----------------------------------------------------------------------------
module subset_enumerator_unit (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // member_count, member_id_0 .. member_id_3
  input  logic [subenum_pkg::IN_DATA_W-1:0]  in_tdata,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // subset_mask, subset_size, packed_id_0 .. packed_id_3
  output logic [subenum_pkg::OUT_DATA_W-1:0] out_tdata,
  output logic                               out_tlast
);
  import subenum_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  subenum_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .sts        (sts),
    .cmd        (cmd)
  );

  subenum_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .cmd       (cmd),
    .sts       (sts)
  );

endmodule

// ===== bench/subset_enumerator_unit_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// subset_enumerator_unit_test
// Sends member lists and checks every subset beat against a local
// binary-counter model. Idling on both sides is varied by phase.
// ----------------------------------------------------------------------------
module subset_enumerator_unit_test;
  import subenum_pkg::*;

  typedef logic [MAX_MEMBERS-1:0][ID_WIDTH-1:0] id_list_t;

  typedef struct packed {
    logic [MAX_MEMBERS-1:0] mask;
    logic [CNT_W-1:0]       size;
    id_list_t               ids;
    logic                   last;
  } subset_t;

  class subset_tracker;
    subset_t pending_subsets[$];
    int      mismatches = 0;

    function void note_request(logic [CNT_W-1:0] count, id_list_t ids);
      int      members;
      int      final_mask;
      int      m;
      int      pos;
      subset_t s;
      members = (count > MAX_MEMBERS) ? MAX_MEMBERS : int'(count);
      if (members == 0) return;
      final_mask = (1 << members) - 1;
      for (m = 1; m <= final_mask; m++) begin
        s = '0;
        s.mask = m[MAX_MEMBERS-1:0];
        for (pos = 0; pos < members; pos++) begin
          if (m[pos]) begin
            s.ids[s.size] = ids[pos];
            s.size++;
          end
        end
        s.last = (m == final_mask);
        pending_subsets.insert(pending_subsets.size(), s);
      end
    endfunction

    function void check_subset(logic [OUT_DATA_W-1:0] data, logic last);
      subset_t want;
      subset_t got;
      int      k;
      got.mask = data[MAX_MEMBERS-1:0];
      got.size = data[OUT_SZ_LSB +: CNT_W];
      got.ids  = data[OUT_ID_LSB +: MAX_MEMBERS*ID_WIDTH];
      got.last = last;
      if (pending_subsets.size() == 0) begin
        $error("unexpected beat: mask %0h size %0d", got.mask, got.size);
        mismatches++;
        return;
      end
      want = pending_subsets.pop_front();
      if (got.mask !== want.mask) begin
        $error("subset_mask: expected %0h, got %0h", want.mask, got.mask);
        mismatches++;
      end
      if (got.size !== want.size) begin
        $error("subset_size: expected %0d, got %0d", want.size, got.size);
        mismatches++;
      end
      for (k = 0; k < MAX_MEMBERS; k++) begin
        if (got.ids[k] !== want.ids[k]) begin
          $error("packed_id_%0d: expected %0h, got %0h", k, want.ids[k], got.ids[k]);
          mismatches++;
        end
      end
      if (got.last !== want.last) begin
        $error("last_subset: expected %0b, got %0b", want.last, got.last);
        mismatches++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;

  int src_idle = 15;
  int dst_idle = 55;

  subset_tracker tracker = new();

  subset_enumerator_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= dst_idle);
  end

  // results first: a request accepted on this edge yields beats only later
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) tracker.check_subset(out_tdata, out_tlast);
    if (rst_n && in_tvalid && in_tready) begin
      tracker.note_request(in_tdata[CNT_W-1:0],
                           in_tdata[IN_ID_LSB +: MAX_MEMBERS*ID_WIDTH]);
    end
  end

  // called at a falling edge, returns at the falling edge after the beat
  task automatic send_request(input logic [CNT_W-1:0] count, input id_list_t ids);
    logic [IN_DATA_W-1:0] beat;
    while ($urandom_range(99) < src_idle) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    beat = '0;
    beat[CNT_W-1:0] = count;
    beat[IN_ID_LSB +: MAX_MEMBERS*ID_WIDTH] = ids;
    in_tvalid <= 1'b1;
    in_tdata  <= beat;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic send_random(input int items);
    id_list_t         ids;
    logic [CNT_W-1:0] count;
    int               pick;
    int               i;
    int               k;
    for (i = 0; i < items; i++) begin
      pick = $urandom_range(99);
      if (pick < 6) count = '0;
      else if (pick < 14) count = CNT_W'($urandom_range(7, MAX_MEMBERS + 1));
      else count = CNT_W'($urandom_range(MAX_MEMBERS, 1));
      for (k = 0; k < MAX_MEMBERS; k++) ids[k] = ID_WIDTH'($urandom);
      send_request(count, ids);
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send_request(3'd4, {8'hff, 8'hff, 8'hff, 8'hff});
    send_request(3'd4, {8'h00, 8'h00, 8'h00, 8'h00});
    send_request(3'd4, {8'h44, 8'h33, 8'h22, 8'h11});
    send_request(3'd1, {8'h00, 8'h00, 8'h00, 8'hff});
    send_request(3'd1, {8'haa, 8'h55, 8'hcc, 8'h00});
    send_request(3'd2, {8'hde, 8'had, 8'h80, 8'h01});
    send_request(3'd3, {8'hbe, 8'h7f, 8'hfe, 8'h5a});
    // empty requests back to back
    send_request(3'd0, {8'h12, 8'h34, 8'h56, 8'h78});
    send_request(3'd0, {8'hff, 8'hff, 8'hff, 8'hff});
    send_request(3'd2, {8'hff, 8'hff, 8'h0f, 8'hf0});
    // counts above the member limit saturate
    send_request(3'd5, {8'h04, 8'h03, 8'h02, 8'h01});
    send_request(3'd6, {8'hc3, 8'h3c, 8'h96, 8'h69});
    send_request(3'd7, {8'h01, 8'h80, 8'h7f, 8'hfe});
    send_request(3'd0, {8'h00, 8'h00, 8'h00, 8'h00});
    send_request(3'd3, {8'hee, 8'h00, 8'hff, 8'h01});
    send_request(3'd1, {8'h99, 8'h88, 8'h77, 8'h66});

    send_random(127);
    src_idle = 55;
    dst_idle = 15;
    send_random(127);
    src_idle = 0;
    dst_idle = 0;
    send_random(126);
    in_tvalid <= 1'b0;

    while (tracker.pending_subsets.size() != 0) @(posedge clk);
    dst_idle = 0;
    repeat (20) @(posedge clk);
    if (tracker.mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
